FILE: design/ffra_pkg.sv
// shared constants and types of the first-fit region allocator
package ffra_pkg;

  localparam int MEM_UNITS_DEF   = 1024;
  localparam int MAX_REGIONS_DEF = 16;

  localparam int CMD_W    = 2;
  localparam int OWNER_W  = 8;
  localparam int SIZE_W   = 16;
  localparam int STATUS_W = 2;
  localparam int START_W  = 10;
  localparam int USAGE_W  = 7;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // table update request from the sequencer
  typedef struct packed {
    logic alloc;
    logic release_entry;
  } wr_op_t;

endpackage

FILE: design/ffra_table.sv
// region table: entry storage, indexed read and candidate overlap check
module ffra_table #(
  parameter int MEM_UNITS   = ffra_pkg::MEM_UNITS_DEF,
  parameter int MAX_REGIONS = ffra_pkg::MAX_REGIONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ffra_pkg::wr_op_t                wr_op,
  input  logic [$clog2(MAX_REGIONS)-1:0]  wr_idx,
  input  logic [ffra_pkg::OWNER_W-1:0]    wr_owner,
  input  logic [$clog2(MEM_UNITS)-1:0]    wr_start,
  input  logic [$clog2(MEM_UNITS+1)-1:0]  wr_end,
  input  logic [$clog2(MAX_REGIONS)-1:0]  rd_idx,
  output logic                            rd_valid,
  output logic [ffra_pkg::OWNER_W-1:0]    rd_owner,
  output logic [$clog2(MEM_UNITS)-1:0]    rd_start,
  output logic [$clog2(MEM_UNITS+1)-1:0]  rd_end,
  input  logic [$clog2(MEM_UNITS+1)-1:0]  cand,
  input  logic [ffra_pkg::SIZE_W-1:0]     size,
  output logic                            fit
);

  localparam int AW = $clog2(MEM_UNITS);
  localparam int EW = $clog2(MEM_UNITS + 1);
  localparam int CW = ((EW > ffra_pkg::SIZE_W) ? EW : ffra_pkg::SIZE_W) + 1;

  logic                       valid [MAX_REGIONS];
  logic [ffra_pkg::OWNER_W-1:0] owner [MAX_REGIONS];
  logic [AW-1:0]              start [MAX_REGIONS];
  logic [EW-1:0]              stop  [MAX_REGIONS];

  logic [CW-1:0]          cand_end;
  logic [MAX_REGIONS-1:0] conflict;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_REGIONS; i++) begin
        valid[i] <= 1'b0;
      end
    end else if (wr_op.alloc) begin
      valid[wr_idx] <= 1'b1;
    end else if (wr_op.release_entry) begin
      valid[wr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_op.alloc) begin
      owner[wr_idx] <= wr_owner;
      start[wr_idx] <= wr_start;
      stop[wr_idx]  <= wr_end;
    end
  end

  assign rd_valid = valid[rd_idx];
  assign rd_owner = owner[rd_idx];
  assign rd_start = start[rd_idx];
  assign rd_end   = stop[rd_idx];

  // candidate span [cand, cand+size) against every live region
  assign cand_end = CW'(cand) + CW'(size);

  always_comb begin
    for (int j = 0; j < MAX_REGIONS; j++) begin
      conflict[j] = valid[j] && (CW'(start[j]) < cand_end) && (stop[j] > cand);
    end
  end

  assign fit = (cand_end <= CW'(MEM_UNITS)) && !(|conflict);

endmodule

FILE: design/ffra_usage.sv
// usage percent: scaled total times a fixed reciprocal of the memory size
module ffra_usage #(
  parameter int MEM_UNITS = ffra_pkg::MEM_UNITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [$clog2(MEM_UNITS+1)-1:0]      used,
  output logic                                done,
  output logic [ffra_pkg::USAGE_W-1:0]        quot
);

  localparam int UW = $clog2(MEM_UNITS + 1);
  localparam int NW = UW + ffra_pkg::USAGE_W;
  localparam int MW = $clog2(MEM_UNITS);
  localparam int KS = NW + MW;
  localparam int RW = NW + 2;
  localparam int PW = NW + RW;
  // 2**KS over the memory size, rounded up: exact for every numerator below 2**NW
  localparam longint unsigned RECIP =
    ((64'd1 << KS) + 64'(MEM_UNITS) - 64'd1) / 64'(MEM_UNITS);
  localparam logic [RW-1:0] RECIP_K = RW'(RECIP);

  logic [NW-1:0] num;
  logic [PW-1:0] prod;
  logic          num_v;
  logic          prod_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_v  <= 1'b0;
      prod_v <= 1'b0;
      done   <= 1'b0;
    end else begin
      num_v  <= start;
      prod_v <= num_v;
      done   <= prod_v;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // rounded half up: add half the divisor before dividing
      num <= NW'(used) * NW'(100) + NW'(MEM_UNITS / 2);
    end
    if (num_v) begin
      prod <= PW'(num) * PW'(RECIP_K);
    end
    if (prod_v) begin
      quot <= prod[KS +: ffra_pkg::USAGE_W];
    end
  end

endmodule

FILE: design/first_fit_region_allocator_unit.sv
// top level of the first-fit region allocator: sequencer and stream ports
//
// usage:
//   s_axis carries one command beat: alloc, free or query for an owner id,
//   with a requested size for alloc. m_axis returns one result beat per
//   command: status, region start (zero unless status is ok) and the
//   memory usage in percent, rounded half up, after the command.
//   the block takes one command at a time; s_axis_tready is high only
//   while it is idle. a command sweeps the table one entry per cycle,
//   checking owner match, free slot and one first-fit candidate (address
//   zero or the end of that entry) against all live regions in parallel.
//   from accept to result valid a command passes the sweep (a step for
//   address zero, then one per entry), the decision and write-back state,
//   the usage launch, the usage pipeline (numerator, product, quotient)
//   and the output load. a new command is not taken before the last
//   result loads; the next command can be taken in the cycle after the
//   result loads.
//   the result waits in an output register; a stalled receiver holds it
//   and the block stalls only when a new result is ready to load.
//   reset empties the table, zeroes the usage total and drops m_axis_tvalid.
module first_fit_region_allocator_unit #(
  parameter int MEM_UNITS   = ffra_pkg::MEM_UNITS_DEF,
  parameter int MAX_REGIONS = ffra_pkg::MAX_REGIONS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] cmd, [9:2] owner_id, [25:10] req_size, rest zero
  input  logic [ffra_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] status, [11:2] region_start, [18:12] usage_percent, rest zero
  output logic [ffra_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int AW   = $clog2(MEM_UNITS);
  localparam int EW   = $clog2(MEM_UNITS + 1);
  localparam int CW   = ((EW > ffra_pkg::SIZE_W) ? EW : ffra_pkg::SIZE_W) + 1;
  localparam int IW   = $clog2(MAX_REGIONS);
  localparam int CNTW = $clog2(MAX_REGIONS + 1);
  localparam int RES_W = ffra_pkg::STATUS_W + ffra_pkg::START_W + ffra_pkg::USAGE_W;

  typedef enum logic [2:0] {
    IDLE,
    SWEEP,
    DECIDE,
    DIV_GO,
    DIVIDE,
    EMIT
  } state_t;

  state_t state;

  // latched command beat
  logic [ffra_pkg::CMD_W-1:0]   cmd;
  logic [ffra_pkg::OWNER_W-1:0] owner;
  logic [ffra_pkg::SIZE_W-1:0]  size;

  // sweep position: step 0 tests address zero, step k looks at entry k-1
  logic [CNTW-1:0] cnt;

  // sweep findings
  logic          match_v;
  logic [IW-1:0] match_idx;
  logic [AW-1:0] match_start;
  logic [EW-1:0] match_end;
  logic          free_v;
  logic [IW-1:0] free_idx;
  logic          best_v;
  logic [EW-1:0] best;

  logic [EW-1:0] used_total;

  // result held between decision and output
  logic [ffra_pkg::STATUS_W-1:0] res_status;
  logic [AW-1:0]                 res_start;

  // table read and candidate check
  logic [IW-1:0]                rd_idx;
  logic                         rd_valid;
  logic [ffra_pkg::OWNER_W-1:0] rd_owner;
  logic [AW-1:0]                rd_start;
  logic [EW-1:0]                rd_end;
  logic [EW-1:0]                cand;
  logic                         cand_ok;
  logic                         fit;
  logic                         first_step;

  // decision
  ffra_pkg::wr_op_t              wr_op;
  logic [IW-1:0]                 wr_idx;
  logic [EW-1:0]                 alloc_end;
  logic [ffra_pkg::STATUS_W-1:0] dec_status;
  logic [AW-1:0]                 dec_start;
  logic [EW-1:0]                 used_next;

  logic                         div_start;
  logic                         div_done;
  logic [ffra_pkg::USAGE_W-1:0] usage;
  logic                         out_free;

  assign s_axis_tready = (state == IDLE);
  assign first_step    = (cnt == '0);
  assign rd_idx        = IW'(cnt - CNTW'(1));
  assign cand          = first_step ? '0 : rd_end;
  assign cand_ok       = first_step || rd_valid;
  assign alloc_end     = EW'(CW'(best) + CW'(size));
  assign div_start     = (state == DIV_GO);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  ffra_table #(
    .MEM_UNITS   (MEM_UNITS),
    .MAX_REGIONS (MAX_REGIONS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_op    (wr_op),
    .wr_idx   (wr_idx),
    .wr_owner (owner),
    .wr_start (AW'(best)),
    .wr_end   (alloc_end),
    .rd_idx   (rd_idx),
    .rd_valid (rd_valid),
    .rd_owner (rd_owner),
    .rd_start (rd_start),
    .rd_end   (rd_end),
    .cand     (cand),
    .size     (size),
    .fit      (fit)
  );

  ffra_usage #(
    .MEM_UNITS (MEM_UNITS)
  ) u_usage (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .used  (used_total),
    .done  (div_done),
    .quot  (usage)
  );

  // command decision from the sweep findings, applied in DECIDE
  always_comb begin
    wr_op      = '0;
    wr_idx     = free_idx;
    dec_status = ffra_pkg::ST_OK;
    dec_start  = '0;
    used_next  = used_total;
    unique case (cmd)
      ffra_pkg::CMD_ALLOC: begin
        if (match_v) begin
          // owner already holds a region: report it, change nothing
          dec_start = match_start;
        end else if (size == '0) begin
          dec_status = ffra_pkg::ST_NOSPACE;
        end else if (!free_v) begin
          dec_status = ffra_pkg::ST_FULL;
        end else if (!best_v) begin
          dec_status = ffra_pkg::ST_NOSPACE;
        end else begin
          wr_op.alloc = (state == DECIDE);
          dec_start   = AW'(best);
          used_next   = used_total + EW'(size);
        end
      end
      ffra_pkg::CMD_FREE: begin
        wr_idx = match_idx;
        if (!match_v) begin
          dec_status = ffra_pkg::ST_NOTFOUND;
        end else begin
          wr_op.release_entry = (state == DECIDE);
          dec_start           = match_start;
          used_next           = used_total - (match_end - EW'(match_start));
        end
      end
      default: begin
        // query, and the unused code behaves as query
        if (!match_v) begin
          dec_status = ffra_pkg::ST_NOTFOUND;
        end else begin
          dec_start = match_start;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      m_axis_tvalid <= 1'b0;
      used_total    <= '0;
    end else begin
      // in EMIT a beat leaving this cycle is replaced by the new one
      if (m_axis_tvalid && m_axis_tready && state != EMIT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            cmd     <= s_axis_tdata[1:0];
            owner   <= s_axis_tdata[9:2];
            size    <= s_axis_tdata[25:10];
            cnt     <= '0;
            match_v <= 1'b0;
            free_v  <= 1'b0;
            best_v  <= 1'b0;
            state   <= SWEEP;
          end
        end
        SWEEP: begin
          // keep the lowest fitting candidate, i.e. the first gap in address order
          if (cand_ok && fit && (!best_v || cand < best)) begin
            best_v <= 1'b1;
            best   <= cand;
          end
          if (!first_step) begin
            if (rd_valid && rd_owner == owner && !match_v) begin
              match_v     <= 1'b1;
              match_idx   <= rd_idx;
              match_start <= rd_start;
              match_end   <= rd_end;
            end
            if (!rd_valid && !free_v) begin
              free_v   <= 1'b1;
              free_idx <= rd_idx;
            end
          end
          if (cnt == CNTW'(MAX_REGIONS)) begin
            state <= DECIDE;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        DECIDE: begin
          res_status <= dec_status;
          res_start  <= dec_start;
          used_total <= used_next;
          state      <= DIV_GO;
        end
        DIV_GO: begin
          state <= DIVIDE;
        end
        DIVIDE: begin
          if (div_done) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {(ffra_pkg::OUT_TDATA_W - RES_W)'(0), usage,
                              ffra_pkg::START_W'(res_start), res_status};
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used_total <= EW'(MEM_UNITS))
    else $error("usage total exceeds memory size");

  a_accept_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state == SWEEP && cnt == '0)
    else $error("accepted beat did not start a sweep");

  a_usage_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[18:12] <= 7'd100)
    else $error("usage percent above 100");

  a_start_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] != ffra_pkg::ST_OK |-> m_axis_tdata[11:2] == '0)
    else $error("region start nonzero on failed command");

  a_write_only_in_decide: assert property (@(posedge clk) disable iff (rst)
    wr_op.alloc || wr_op.release_entry |->
      state == DECIDE && !(wr_op.alloc && wr_op.release_entry))
    else $error("table write outside decision cycle");
`endif

endmodule
